// ----- hw/rtl/lwfs_pkg.sv -----
// Shared types, constants and helpers for the window fill serializer.
package lwfs_pkg;

	localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
	localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
	localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

	// Header step codes; the last one marks the pixel phase
	localparam logic [2:0] STEP_COL_CMD  = 3'd0;
	localparam logic [2:0] STEP_X_FIRST  = 3'd1;
	localparam logic [2:0] STEP_X_LAST   = 3'd2;
	localparam logic [2:0] STEP_PAGE_CMD = 3'd3;
	localparam logic [2:0] STEP_Y_FIRST  = 3'd4;
	localparam logic [2:0] STEP_Y_LAST   = 3'd5;
	localparam logic [2:0] STEP_MEM_CMD  = 3'd6;
	localparam logic [2:0] STEP_PIXEL    = 3'd7;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	localparam logic [2:0] BIT_LSB = 3'd7;

	typedef struct packed {
		logic        kind;
		logic [7:0]  x_start;
		logic [7:0]  x_end;
		logic [7:0]  y_start;
		logic [7:0]  y_end;
		logic [15:0] pixel_count;
		logic [7:0]  fill_color;
		logic        random_mode;
	} req_t;

	typedef struct packed {
		logic line_bit;
		logic is_command;
		logic select_pulse;
		logic byte_end;
		logic block_end;
	} rsp_t;

	typedef struct packed {
		logic [7:0] x_first;
		logic [7:0] x_last;
		logic [7:0] y_first;
		logic [7:0] y_last;
	} window_t;

	// Byte sent at a given header step
	function automatic logic [7:0] header_byte(input logic [2:0] step, input window_t win);
		logic [7:0] b;
		case (step)
			STEP_COL_CMD:  b = CMD_COLUMN_SET;
			STEP_X_FIRST:  b = win.x_first;
			STEP_X_LAST:   b = win.x_last;
			STEP_PAGE_CMD: b = CMD_PAGE_SET;
			STEP_Y_FIRST:  b = win.y_first;
			STEP_Y_LAST:   b = win.y_last;
			default:       b = CMD_MEMORY_WRITE;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] rotl(input logic [7:0] v, input logic [2:0] s);
		logic [15:0] w;
		w = {v, v} << s;
		return w[15:8];
	endfunction

endpackage

// ----- hw/rtl/lwfs_if.sv -----
// Valid/ready channel interfaces for the request and response streams.
interface lwfs_req_if;
	import lwfs_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lwfs_rsp_if;
	import lwfs_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/lwfs_gen.sv -----
// Five-register 8-bit pseudo-random byte generator for random fill mode.
module lwfs_gen (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	output logic [7:0] rnd_byte
);
	import lwfs_pkg::*;

	logic [7:0]  gq_q, gg_q, gx_q, ga_q, gb_q;
	logic [15:0] prod;

	assign rnd_byte = gq_q;
	assign prod     = {8'd0, ga_q} * {8'd0, gg_q};

	// Advance the generator once per random pixel byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gq_q <= 8'd0;
			gg_q <= 8'd0;
			gx_q <= 8'd0;
			ga_q <= 8'd1;
			gb_q <= 8'd1;
		end else if (step) begin
			gq_q <= gg_q ^ rotl(gx_q, 3'd1);
			gg_q <= gq_q ^ rotl(gg_q, 3'd2);
			gx_q <= prod[7:0] + gb_q;
			ga_q <= ga_q + 8'd2;
			gb_q <= gb_q + 8'd2;
		end
	end

endmodule

// ----- hw/rtl/lwfs_ser.sv -----
// Window write sequencer: header bytes, pixel bytes and per-bit flags.
module lwfs_ser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  lwfs_pkg::req_t item,
	input  logic [7:0]     rnd_byte,
	output logic           gen_step,
	output logic           rsp_valid,
	output lwfs_pkg::rsp_t rsp
);
	import lwfs_pkg::*;

	logic        busy_q;
	logic [2:0]  step_q;
	logic [15:0] left_q;
	logic [2:0]  bitpos_q;
	logic [7:0]  cur_q;
	window_t     win_q;
	logic [7:0]  color_q;
	logic        mode_q;

	logic tick, start, cmd, bend, in_header, last_byte;

	assign start     = fire && (item.kind == KIND_START) && !busy_q;
	assign tick      = fire && (item.kind == KIND_TICK) && busy_q;
	assign cmd       = (step_q == STEP_COL_CMD) || (step_q == STEP_PAGE_CMD) ||
	                   (step_q == STEP_MEM_CMD);
	assign bend      = (bitpos_q == BIT_LSB);
	assign in_header = (step_q < STEP_MEM_CMD);
	assign last_byte = !in_header && (left_q == 16'd0);
	assign gen_step  = tick && bend && !in_header && !last_byte && mode_q;

	// Flags for the bit sent by this tick
	always_comb begin
		rsp_valid         = tick;
		rsp.line_bit      = cur_q[BIT_LSB - bitpos_q];
		rsp.is_command    = cmd;
		rsp.select_pulse  = cmd && (bitpos_q == 3'd0);
		rsp.byte_end      = bend;
		rsp.block_end     = bend && last_byte;
	end

	// Control state: load on start, advance bit and byte on tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= STEP_COL_CMD;
			left_q   <= 16'd0;
			bitpos_q <= 3'd0;
			cur_q    <= 8'd0;
			win_q    <= '0;
			color_q  <= 8'd0;
			mode_q   <= 1'b0;
		end else if (start) begin
			win_q    <= '{x_first: item.x_start, x_last: item.x_end,
			              y_first: item.y_start, y_last: item.y_end};
			left_q   <= item.pixel_count;
			color_q  <= item.fill_color;
			mode_q   <= item.random_mode;
			step_q   <= STEP_COL_CMD;
			bitpos_q <= 3'd0;
			cur_q    <= CMD_COLUMN_SET;
			busy_q   <= 1'b1;
		end else if (tick) begin
			if (bend) begin
				bitpos_q <= 3'd0;
				if (in_header) begin
					step_q <= step_q + 3'd1;
					cur_q  <= header_byte(step_q + 3'd1, win_q);
				end else if (last_byte) begin
					busy_q <= 1'b0;
					step_q <= STEP_COL_CMD;
					cur_q  <= 8'd0;
				end else begin
					step_q <= STEP_PIXEL;
					left_q <= left_q - 16'd1;
					cur_q  <= mode_q ? rnd_byte : color_q;
				end
			end else begin
				bitpos_q <= bitpos_q + 3'd1;
			end
		end
	end

endmodule

// ----- hw/rtl/lcd_window_fill_serializer_core.sv -----
// Top level of the window fill serializer: request intake and result register.
//
//  channel | dir | payload                                   | transaction
//  req     | in  | kind, window, pixel_count, color, mode     | start or one tick
//  rsp     | out | line_bit, is_command, select_pulse, flags  | one serial bit
//
// Each request is handled in the cycle it is accepted; a tick's bit is on rsp in
// the next cycle from the result register; one tick per clock unless rsp stalls.
// arst_n clears the sequencer and result valid; the generator resets to its seed.
// A stalled rsp holds req.ready low only while the result register is full and
// not being drained.
module lcd_window_fill_serializer_core (
	input logic        clk,
	input logic        arst_n,
	lwfs_req_if.sink   req,
	lwfs_rsp_if.source rsp
);
	import lwfs_pkg::*;

	logic       fire, bit_valid, gen_step;
	logic [7:0] rnd_byte;
	rsp_t       bit_rsp;
	rsp_t       res_q;
	logic       res_valid_q;

	assign req.ready = !res_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	lwfs_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (req.data),
		.rnd_byte (rnd_byte),
		.gen_step (gen_step),
		.rsp_valid(bit_valid),
		.rsp      (bit_rsp)
	);

	lwfs_gen u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (gen_step),
		.rnd_byte(rnd_byte)
	);

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req.ready) begin
			res_valid_q <= bit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && bit_valid) begin
			res_q <= bit_rsp;
		end
	end

	assign rsp.valid = res_valid_q;
	assign rsp.data  = res_q;

endmodule
